@@ rtl/hydrogen_bond_pair_test_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test assertion macros
// Clocked assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef HYDROGEN_BOND_PAIR_TEST_UNIT_MACROS_SVH
`define HYDROGEN_BOND_PAIR_TEST_UNIT_MACROS_SVH

// property checked on every rising edge outside of reset
`define HBPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define HBPT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test package
// Register codes, reset values, fixed widths and shared structs
// ----------------------------------------------------------------------------
package hbpt_pkg;

	// fixed field widths
	localparam int BOX_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CUT2_W     = 32;
	localparam int DSQ_W      = 34;
	localparam int FLAG_W     = 4;
	localparam int OUT_W      = 40;
	localparam int OUT_PAD_W  = OUT_W - DSQ_W - FLAG_W;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X  = 8'd0,
		REG_BOX_Y  = 8'd1,
		REG_BOX_Z  = 8'd2,
		REG_CUTOFF = 8'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [BOX_W-1:0]  BOX_RESET  = 16'd25600;
	localparam logic [CUT2_W-1:0] CUT2_RESET = 32'd589824;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [BOX_W-1:0]  box_x;
		logic [BOX_W-1:0]  box_y;
		logic [BOX_W-1:0]  box_z;
		logic [CUT2_W-1:0] cut2;
	} cfg_t;

	// per-stage load enables
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} pipe_en_t;

endpackage

@@ rtl/hbpt_cfg.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test configuration registers
// Box lengths and the squared cutoff, squared once at write time
// ----------------------------------------------------------------------------
module hbpt_cfg import hbpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [BOX_W-1:0]  box_x_q;
	logic [BOX_W-1:0]  box_y_q;
	logic [BOX_W-1:0]  box_z_q;
	logic [CUT2_W-1:0] cut2_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BOX_RESET;
			box_y_q <= BOX_RESET;
			box_z_q <= BOX_RESET;
			cut2_q  <= CUT2_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOX_X:  box_x_q <= cfg_data;
				REG_BOX_Y:  box_y_q <= cfg_data;
				REG_BOX_Z:  box_z_q <= cfg_data;
				REG_CUTOFF: cut2_q  <= CUT2_W'(cfg_data) * CUT2_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg.box_x = box_x_q;
	assign cfg.box_y = box_y_q;
	assign cfg.box_z = box_z_q;
	assign cfg.cut2  = cut2_q;

endmodule

@@ rtl/hbpt_ctl.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test pipeline control
// Valid bits per stage and load enables that fill bubbles under stall
// ----------------------------------------------------------------------------
module hbpt_ctl import hbpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output pipe_en_t en
);

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	// a stage loads when it is empty or its word moves on
	always_comb begin
		en.en4 = !v_s4 || m_tready;
		en.en3 = !v_s3 || en.en4;
		en.en2 = !v_s2 || en.en3;
		en.en1 = !v_s1 || en.en2;
	end

	assign s_tready = en.en1;
	assign m_tvalid = v_s4;

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.en1) v_s1 <= s_tvalid;
			if (en.en2) v_s2 <= v_s1;
			if (en.en3) v_s3 <= v_s2;
			if (en.en4) v_s4 <= v_s3;
		end
	end

endmodule

@@ rtl/hbpt_dist_lane.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test distance lane
// One axis: difference, minimum image fold and square over three stages
// ----------------------------------------------------------------------------
module hbpt_dist_lane import hbpt_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int MW = COORD_BITS + 1,
	localparam int CW = (MW > BOX_W) ? MW : BOX_W
) (
	input  logic                         clk,
	input  pipe_en_t                     en,
	input  logic signed [COORD_BITS-1:0] hyd,
	input  logic signed [COORD_BITS-1:0] acc,
	input  logic [BOX_W-1:0]             box,
	output logic [2*CW-1:0]              sq_s3
);

	logic signed [MW-1:0] d_ha;
	logic signed [MW-1:0] d_ah;
	logic [MW-1:0]        mag_s1;
	logic [CW:0]          mag_w;
	logic [CW:0]          box_w;
	logic [CW:0]          two_mag;
	logic [CW:0]          bm;
	logic [CW:0]          mb;
	logic [CW-1:0]        c_fold;
	logic [CW-1:0]        c_s2;

	// stage 1: magnitude of hydrogen minus acceptor
	assign d_ha = MW'(hyd) - MW'(acc);
	assign d_ah = MW'(acc) - MW'(hyd);

	always_ff @(posedge clk) begin
		if (en.en1) mag_s1 <= d_ha[MW-1] ? d_ah : d_ha;
	end

	// stage 2: fold to box minus magnitude past half the box, or magnitude minus box past the box
	always_comb begin
		mag_w   = (CW+1)'(mag_s1);
		box_w   = (CW+1)'(box);
		two_mag = mag_w << 1;
		bm      = box_w - mag_w;
		mb      = mag_w - box_w;
		if (two_mag <= box_w) begin
			c_fold = mag_w[CW-1:0];
		end else if (bm[CW]) begin
			c_fold = mb[CW-1:0];
		end else begin
			c_fold = bm[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en2) c_s2 <= c_fold;
	end

	// stage 3: square
	always_ff @(posedge clk) begin
		if (en.en3) sq_s3 <= (2*CW)'(c_s2) * (2*CW)'(c_s2);
	end

endmodule

@@ rtl/hbpt_angle.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test angle unit
// Two cross products and their per-axis dot terms over three stages
// ----------------------------------------------------------------------------
module hbpt_angle import hbpt_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int PW = 2 * COORD_BITS,
	localparam int XW = PW + 1,
	localparam int QW = 2 * XW
) (
	input  logic                         clk,
	input  pipe_en_t                     en,
	input  logic signed [COORD_BITS-1:0] don [3],
	input  logic signed [COORD_BITS-1:0] hyd [3],
	input  logic signed [COORD_BITS-1:0] acc [3],
	output logic signed [QW-1:0]         q_s3 [3],
	output logic                         nz_s3
);

	logic signed [PW-1:0] pd_a_s1 [3];
	logic signed [PW-1:0] pd_b_s1 [3];
	logic signed [PW-1:0] pa_a_s1 [3];
	logic signed [PW-1:0] pa_b_s1 [3];
	logic signed [XW-1:0] c1_s2 [3];
	logic signed [XW-1:0] c2_s2 [3];

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int I = (k + 1) % 3;
		localparam int J = (k + 2) % 3;

		// stage 1: partial products of both cross products
		always_ff @(posedge clk) begin
			if (en.en1) begin
				pd_a_s1[k] <= PW'(don[I]) * PW'(hyd[J]);
				pd_b_s1[k] <= PW'(don[J]) * PW'(hyd[I]);
				pa_a_s1[k] <= PW'(acc[I]) * PW'(hyd[J]);
				pa_b_s1[k] <= PW'(acc[J]) * PW'(hyd[I]);
			end
		end

		// stage 2: cross product components
		always_ff @(posedge clk) begin
			if (en.en2) begin
				c1_s2[k] <= XW'(pd_a_s1[k]) - XW'(pd_b_s1[k]);
				c2_s2[k] <= XW'(pa_a_s1[k]) - XW'(pa_b_s1[k]);
			end
		end

		// stage 3: dot product terms
		always_ff @(posedge clk) begin
			if (en.en3) q_s3[k] <= QW'(c1_s2[k]) * QW'(c2_s2[k]);
		end
	end

	// stage 3: both cross products must be nonzero vectors
	always_ff @(posedge clk) begin
		if (en.en3) begin
			nz_s3 <= ((c1_s2[0] != '0) || (c1_s2[1] != '0) || (c1_s2[2] != '0)) &&
				((c2_s2[0] != '0) || (c2_s2[1] != '0) || (c2_s2[2] != '0));
		end
	end

endmodule

@@ rtl/hydrogen_bond_pair_test_unit.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test unit
// Tests one donor, hydrogen, acceptor triple per word for contact and bond
// ----------------------------------------------------------------------------
// One candidate pair enters per clock, one word per cycle while the output
// is not stalled, and its result passes through four register stages
// (difference and partial products, minimum image fold and cross products,
// squares and dot terms, sums and compares into the output register).
// Stalls on the output back up stage by stage, and empty stages keep
// taking words while a result waits. The squared cutoff is formed when the
// cutoff register is written, so there is no start-up or clearing period.
// ----------------------------------------------------------------------------
module hydrogen_bond_pair_test_unit import hbpt_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int IN_W = ((9 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// donor_x, donor_y, donor_z, hydrogen_x, hydrogen_y, hydrogen_z,
	// acceptor_x, acceptor_y, acceptor_z, zero fill
	input  logic [IN_W-1:0]       s_tdata,
	// acceptor_is_main
	input  logic                  s_tuser,
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// contact, bond, bond_main, bond_side, distance_squared, zero fill
	output logic [OUT_W-1:0]      m_tdata,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MW = COORD_BITS + 1;
	localparam int CW = (MW > BOX_W) ? MW : BOX_W;
	localparam int SW = 2 * CW + 2;
	localparam int QW = 2 * (2 * COORD_BITS + 1);
	localparam int DW = QW + 2;

	cfg_t     cfg;
	pipe_en_t en;

	logic signed [COORD_BITS-1:0] don [3];
	logic signed [COORD_BITS-1:0] hyd [3];
	logic signed [COORD_BITS-1:0] acc [3];
	logic [2*CW-1:0]              sq_x_s3;
	logic [2*CW-1:0]              sq_y_s3;
	logic [2*CW-1:0]              sq_z_s3;
	logic signed [QW-1:0]         q_s3 [3];
	logic                         nz_s3;
	logic                         main_s1;
	logic                         main_s2;
	logic                         main_s3;
	logic [SW-1:0]                dsq_sum;
	logic signed [DW-1:0]         dot_sum;
	logic                         contact_c;
	logic                         bond_c;
	logic                         contact_s4;
	logic                         bond_s4;
	logic                         bond_main_s4;
	logic                         bond_side_s4;
	logic [DSQ_W-1:0]             dsq_s4;

	hbpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hbpt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	// unpack coordinates
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			don[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
			hyd[k] = s_tdata[(3+k)*COORD_BITS +: COORD_BITS];
			acc[k] = s_tdata[(6+k)*COORD_BITS +: COORD_BITS];
		end
	end

	// distance lanes, one per axis
	hbpt_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
		.clk   (clk),
		.en    (en),
		.hyd   (hyd[0]),
		.acc   (acc[0]),
		.box   (cfg.box_x),
		.sq_s3 (sq_x_s3)
	);

	hbpt_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
		.clk   (clk),
		.en    (en),
		.hyd   (hyd[1]),
		.acc   (acc[1]),
		.box   (cfg.box_y),
		.sq_s3 (sq_y_s3)
	);

	hbpt_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
		.clk   (clk),
		.en    (en),
		.hyd   (hyd[2]),
		.acc   (acc[2]),
		.box   (cfg.box_z),
		.sq_s3 (sq_z_s3)
	);

	hbpt_angle #(.COORD_BITS(COORD_BITS)) u_angle (
		.clk   (clk),
		.en    (en),
		.don   (don),
		.hyd   (hyd),
		.acc   (acc),
		.q_s3  (q_s3),
		.nz_s3 (nz_s3)
	);

	// main chain flag rides along
	always_ff @(posedge clk) begin
		if (en.en1) main_s1 <= s_tuser;
		if (en.en2) main_s2 <= main_s1;
		if (en.en3) main_s3 <= main_s2;
	end

	// stage 4: sums and compares
	always_comb begin
		dsq_sum   = SW'(sq_x_s3) + SW'(sq_y_s3) + SW'(sq_z_s3);
		dot_sum   = DW'(q_s3[0]) + DW'(q_s3[1]) + DW'(q_s3[2]);
		contact_c = (dsq_sum != '0) && (dsq_sum < SW'(cfg.cut2));
		bond_c    = contact_c && nz_s3 && (dot_sum[DW-1] || (dot_sum == '0));
	end

	// output register
	always_ff @(posedge clk) begin
		if (en.en4) begin
			contact_s4   <= contact_c;
			bond_s4      <= bond_c;
			bond_main_s4 <= bond_c && main_s3;
			bond_side_s4 <= bond_c && !main_s3;
			dsq_s4       <= dsq_sum[DSQ_W-1:0];
		end
	end

	assign m_tdata = {{OUT_PAD_W{1'b0}}, dsq_s4, bond_side_s4, bond_main_s4,
		bond_s4, contact_s4};

endmodule

@@ rtl/hbpt_checker.sv @@
// ----------------------------------------------------------------------------
// Hydrogen bond pair test checker
// Port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "hydrogen_bond_pair_test_unit_macros.svh"

module hbpt_checker import hbpt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// no result word shows in the cycle after reset is held
	`HBPT_ASSERT_RST(a_rst_quiet, !arst_n |=> !m_tvalid, "result valid after reset held")

	// a stalled result word holds
	`HBPT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// bond needs contact, and splits into exactly one of main or side
	`HBPT_ASSERT(a_flags, m_tvalid |-> (!m_tdata[1] || m_tdata[0]) && ((m_tdata[2] || m_tdata[3]) == m_tdata[1]) && !(m_tdata[2] && m_tdata[3]), "inconsistent bond flags")

	// a contact never has a zero distance
	`HBPT_ASSERT(a_contact_dist, m_tvalid && m_tdata[0] |-> m_tdata[DSQ_W+FLAG_W-1:FLAG_W] != '0, "contact with zero distance")

endmodule

bind hydrogen_bond_pair_test_unit hbpt_checker u_hbpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
